[hdl/epoch_to_calendar_date_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the epoch to calendar date block
// Each macro checks a property sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef EPOCH_TO_CALENDAR_DATE_MACROS_SVH
`define EPOCH_TO_CALENDAR_DATE_MACROS_SVH

// same-cycle implication
`define ECD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ECD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ecd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecd_pkg
// Shared widths, constants, microcode types and month lengths.
// ----------------------------------------------------------------------------
package ecd_pkg;

    localparam int EPOCH_W     = 32;
    localparam int TZ_W        = 17;
    localparam int YEAR_W      = 12;
    localparam int MONTH_W     = 4;
    localparam int DAY_W       = 5;
    localparam int HOUR_W      = 5;
    localparam int MIN_W       = 6;
    localparam int SEC_W       = 6;
    localparam int OUT_TDATA_W = 40;
    localparam int UPC_W       = 4;
    localparam int INC_W       = 4;

    localparam logic signed [TZ_W-1:0] TZ_RESET = 17'sd19800;

    localparam logic [YEAR_W-1:0]  BASE_YEAR   = 12'd1970;
    localparam logic [1:0]         BASE_MOD4   = 2'd2;
    localparam logic [6:0]         BASE_MOD100 = 7'd70;
    localparam logic [8:0]         BASE_MOD400 = 9'd370;
    localparam logic [6:0]         LAST_MOD100 = 7'd99;
    localparam logic [8:0]         LAST_MOD400 = 9'd399;
    localparam logic [MONTH_W-1:0] FIRST_MONTH = 4'd1;
    localparam logic [MONTH_W-1:0] LAST_MONTH  = 4'd12;
    localparam logic [DAY_W-1:0]   FIRST_DAY   = 5'd1;

    localparam logic [EPOCH_W-1:0] SECS_PER_MIN     = 32'd60;
    localparam logic [EPOCH_W-1:0] SECS_PER_10MIN   = 32'd600;
    localparam logic [EPOCH_W-1:0] SECS_PER_HOUR    = 32'd3600;
    localparam logic [EPOCH_W-1:0] SECS_PER_10HOUR  = 32'd36000;
    localparam logic [EPOCH_W-1:0] SECS_PER_DAY     = 32'd86400;
    localparam logic [EPOCH_W-1:0] SECS_PER_10DAY   = 32'd864000;
    localparam logic [EPOCH_W-1:0] SECS_MONTH_28    = 32'd2419200;
    localparam logic [EPOCH_W-1:0] SECS_MONTH_29    = 32'd2505600;
    localparam logic [EPOCH_W-1:0] SECS_MONTH_30    = 32'd2592000;
    localparam logic [EPOCH_W-1:0] SECS_MONTH_31    = 32'd2678400;
    localparam logic [EPOCH_W-1:0] SECS_LEAP_YEAR   = 32'd31622400;
    localparam logic [EPOCH_W-1:0] SECS_COMMON_YEAR = 32'd31536000;

    // microprogram step addresses
    localparam logic [UPC_W-1:0] UPC_WAIT   = 4'd0;
    localparam logic [UPC_W-1:0] UPC_YEAR   = 4'd1;
    localparam logic [UPC_W-1:0] UPC_MONTH  = 4'd2;
    localparam logic [UPC_W-1:0] UPC_DAY10  = 4'd3;
    localparam logic [UPC_W-1:0] UPC_DAY1   = 4'd4;
    localparam logic [UPC_W-1:0] UPC_HOUR10 = 4'd5;
    localparam logic [UPC_W-1:0] UPC_HOUR1  = 4'd6;
    localparam logic [UPC_W-1:0] UPC_MIN10  = 4'd7;
    localparam logic [UPC_W-1:0] UPC_MIN1   = 4'd8;
    localparam logic [UPC_W-1:0] UPC_EMIT   = 4'd9;

    typedef enum logic [1:0] {
        OP_WAIT,
        OP_LOOP,
        OP_EMIT
    } uop_t;

    typedef enum logic [2:0] {
        K_YEAR,
        K_MONTH,
        K_DAY10,
        K_DAY1,
        K_HOUR10,
        K_HOUR1,
        K_MIN10,
        K_MIN1
    } ksel_t;

    typedef enum logic [2:0] {
        D_YEAR,
        D_MONTH,
        D_DAY,
        D_HOUR,
        D_MINUTE
    } dst_t;

    typedef struct packed {
        uop_t             op;
        ksel_t            ksel;
        dst_t             dst;
        logic [INC_W-1:0] inc;
        logic [UPC_W-1:0] target;
    } uctl_t;

    typedef struct packed {
        logic in_valid;
        logic cond;
        logic out_free;
    } seq_status_t;

    function automatic logic [EPOCH_W-1:0] month_secs(
        input logic [MONTH_W-1:0] month,
        input logic               leap
    );
        logic [EPOCH_W-1:0] secs;
        begin
            unique case (month)
                4'd2:                      secs = leap ? SECS_MONTH_29 : SECS_MONTH_28;
                4'd4, 4'd6, 4'd9, 4'd11:   secs = SECS_MONTH_30;
                default:                   secs = SECS_MONTH_31;
            endcase
            return secs;
        end
    endfunction

endpackage

[hdl/epoch_to_calendar_date.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_to_calendar_date
// Converts a 32-bit second count since 1970 plus a zone offset to a local date.
// ----------------------------------------------------------------------------
// Each transaction on the input stream is a UTC second count; tz_offset (set
// through cfg_wr_en/cfg_wr_data, reset 19800) is added modulo 2^32 and one
// result transaction carries the local year, month, day, hour, minute and
// second. One item is converted at a time by a short microprogram that walks
// years, months, tens and units of days, hours and minutes through a single
// compare/subtract unit on the remainder register, from acceptance to the
// result register; the year walk dominates. The next item is taken as soon
// as the result is in the output register.
// ----------------------------------------------------------------------------
module epoch_to_calendar_date (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic signed [ecd_pkg::TZ_W-1:0]        cfg_wr_data,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [31:0] epoch_seconds
    input  logic [ecd_pkg::EPOCH_W-1:0]            s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // [11:0] year, [15:12] month, [20:16] day_of_month, [25:21] hour,
    // [31:26] minute, [37:32] second, [39:38] zero
    output logic [ecd_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);
    import ecd_pkg::*;

    localparam int PAD_W = OUT_TDATA_W - (YEAR_W + MONTH_W + DAY_W + HOUR_W + MIN_W + SEC_W);

    logic signed [TZ_W-1:0]   tz_offset_reg;
    logic                     m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]   m_tdata_reg;

    seq_status_t              status;
    uctl_t                    uctl;
    logic                     in_ready;
    logic                     emit;
    logic                     cond;
    logic                     load;
    logic [YEAR_W-1:0]        year;
    logic [MONTH_W-1:0]       month;
    logic [DAY_W-1:0]         day_of_month;
    logic [HOUR_W-1:0]        hour;
    logic [MIN_W-1:0]         minute;
    logic [SEC_W-1:0]         second;

    assign load            = s_axis_tvalid && in_ready;
    assign status.in_valid = s_axis_tvalid;
    assign status.cond     = cond;
    assign status.out_free = !m_tvalid_reg || m_axis_tready;

    ecd_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .status   (status),
        .uctl     (uctl),
        .in_ready (in_ready),
        .emit     (emit)
    );

    ecd_datapath u_dp (
        .clk           (clk),
        .uctl          (uctl),
        .load          (load),
        .epoch_seconds (s_axis_tdata),
        .tz_offset     (tz_offset_reg),
        .cond          (cond),
        .year          (year),
        .month         (month),
        .day_of_month  (day_of_month),
        .hour          (hour),
        .minute        (minute),
        .second        (second)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tz_offset_reg <= TZ_RESET;
        else if (cfg_wr_en)
            tz_offset_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (emit)
            m_tvalid_reg <= 1'b1;
        else if (m_axis_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            m_tdata_reg <= {{PAD_W{1'b0}}, second, minute, hour, day_of_month, month, year};
    end

    assign s_axis_tready = in_ready;
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

endmodule

[hdl/ecd_ucode_rom.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecd_ucode_rom
// Control store: one control word per microprogram step.
// ----------------------------------------------------------------------------
module ecd_ucode_rom (
    input  logic [ecd_pkg::UPC_W-1:0] upc,
    output ecd_pkg::uctl_t            uctl
);
    import ecd_pkg::*;

    // LOOP steps repeat while the subtract is taken, then fall through
    always_comb
    begin
        unique case (upc)
            UPC_WAIT:   uctl = '{op: OP_WAIT, ksel: K_YEAR,   dst: D_YEAR,   inc: 4'd0,
                                 target: UPC_YEAR};
            UPC_YEAR:   uctl = '{op: OP_LOOP, ksel: K_YEAR,   dst: D_YEAR,   inc: 4'd1,
                                 target: UPC_YEAR};
            UPC_MONTH:  uctl = '{op: OP_LOOP, ksel: K_MONTH,  dst: D_MONTH,  inc: 4'd1,
                                 target: UPC_MONTH};
            UPC_DAY10:  uctl = '{op: OP_LOOP, ksel: K_DAY10,  dst: D_DAY,    inc: 4'd10,
                                 target: UPC_DAY10};
            UPC_DAY1:   uctl = '{op: OP_LOOP, ksel: K_DAY1,   dst: D_DAY,    inc: 4'd1,
                                 target: UPC_DAY1};
            UPC_HOUR10: uctl = '{op: OP_LOOP, ksel: K_HOUR10, dst: D_HOUR,   inc: 4'd10,
                                 target: UPC_HOUR10};
            UPC_HOUR1:  uctl = '{op: OP_LOOP, ksel: K_HOUR1,  dst: D_HOUR,   inc: 4'd1,
                                 target: UPC_HOUR1};
            UPC_MIN10:  uctl = '{op: OP_LOOP, ksel: K_MIN10,  dst: D_MINUTE, inc: 4'd10,
                                 target: UPC_MIN10};
            UPC_MIN1:   uctl = '{op: OP_LOOP, ksel: K_MIN1,   dst: D_MINUTE, inc: 4'd1,
                                 target: UPC_MIN1};
            UPC_EMIT:   uctl = '{op: OP_EMIT, ksel: K_YEAR,   dst: D_YEAR,   inc: 4'd0,
                                 target: UPC_WAIT};
            default:    uctl = '{op: OP_EMIT, ksel: K_YEAR,   dst: D_YEAR,   inc: 4'd0,
                                 target: UPC_WAIT};
        endcase
    end

endmodule

[hdl/ecd_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecd_sequencer
// Step counter with conditional jumps, driven by the control store.
// ----------------------------------------------------------------------------
module ecd_sequencer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ecd_pkg::seq_status_t status,
    output ecd_pkg::uctl_t       uctl,
    output logic                 in_ready,
    output logic                 emit
);
    import ecd_pkg::*;

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    logic             taken;

    ecd_ucode_rom u_rom (
        .upc  (upc_reg),
        .uctl (uctl)
    );

    always_comb
    begin
        unique case (uctl.op)
            OP_WAIT: taken = status.in_valid;
            OP_LOOP: taken = status.cond;
            OP_EMIT: taken = status.out_free;
            default: taken = 1'b1;
        endcase

        // taken jumps to target; an exhausted loop falls through, others hold
        if (taken)
            upc_next = uctl.target;
        else if (uctl.op == OP_LOOP)
            upc_next = upc_reg + UPC_W'(1);
        else
            upc_next = upc_reg;

        in_ready = (uctl.op == OP_WAIT);
        emit     = (uctl.op == OP_EMIT) && status.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            upc_reg <= UPC_WAIT;
        else
            upc_reg <= upc_next;
    end

endmodule

[hdl/ecd_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecd_datapath
// Remainder register with one compare/subtract unit and the date counters.
// ----------------------------------------------------------------------------
module ecd_datapath (
    input  logic                             clk,
    input  ecd_pkg::uctl_t                   uctl,
    input  logic                             load,
    input  logic [ecd_pkg::EPOCH_W-1:0]      epoch_seconds,
    input  logic signed [ecd_pkg::TZ_W-1:0]  tz_offset,
    output logic                             cond,
    output logic [ecd_pkg::YEAR_W-1:0]       year,
    output logic [ecd_pkg::MONTH_W-1:0]      month,
    output logic [ecd_pkg::DAY_W-1:0]        day_of_month,
    output logic [ecd_pkg::HOUR_W-1:0]       hour,
    output logic [ecd_pkg::MIN_W-1:0]        minute,
    output logic [ecd_pkg::SEC_W-1:0]        second
);
    import ecd_pkg::*;

    logic [EPOCH_W-1:0] rem_reg;
    logic [YEAR_W-1:0]  year_reg;
    logic [1:0]         mod4_reg;
    logic [6:0]         mod100_reg;
    logic [8:0]         mod400_reg;
    logic [MONTH_W-1:0] month_reg;
    logic [DAY_W-1:0]   day_reg;
    logic [HOUR_W-1:0]  hour_reg;
    logic [MIN_W-1:0]   minute_reg;

    logic               leap;
    logic [EPOCH_W-1:0] kval;
    logic               step;

    // year residues stand in for the 4/100/400 divisibility tests
    assign leap = ((mod4_reg == 2'd0) && (mod100_reg != 7'd0)) || (mod400_reg == 9'd0);

    always_comb
    begin
        unique case (uctl.ksel)
            K_YEAR:   kval = leap ? SECS_LEAP_YEAR : SECS_COMMON_YEAR;
            K_MONTH:  kval = month_secs(month_reg, leap);
            K_DAY10:  kval = SECS_PER_10DAY;
            K_DAY1:   kval = SECS_PER_DAY;
            K_HOUR10: kval = SECS_PER_10HOUR;
            K_HOUR1:  kval = SECS_PER_HOUR;
            K_MIN10:  kval = SECS_PER_10MIN;
            K_MIN1:   kval = SECS_PER_MIN;
            default:  kval = SECS_PER_MIN;
        endcase
        // the month walk never goes past December
        cond = (rem_reg >= kval) && ((uctl.ksel != K_MONTH) || (month_reg != LAST_MONTH));
        step = (uctl.op == OP_LOOP) && cond;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg    <= epoch_seconds
                          + {{(EPOCH_W-TZ_W){tz_offset[TZ_W-1]}}, tz_offset};
            year_reg   <= BASE_YEAR;
            mod4_reg   <= BASE_MOD4;
            mod100_reg <= BASE_MOD100;
            mod400_reg <= BASE_MOD400;
            month_reg  <= FIRST_MONTH;
            day_reg    <= FIRST_DAY;
            hour_reg   <= '0;
            minute_reg <= '0;
        end
        else if (step)
        begin
            rem_reg <= rem_reg - kval;
            unique case (uctl.dst)
                D_YEAR:
                begin
                    year_reg   <= year_reg + YEAR_W'(1);
                    mod4_reg   <= mod4_reg + 2'd1;
                    mod100_reg <= (mod100_reg == LAST_MOD100) ? 7'd0 : mod100_reg + 7'd1;
                    mod400_reg <= (mod400_reg == LAST_MOD400) ? 9'd0 : mod400_reg + 9'd1;
                end
                D_MONTH:  month_reg  <= month_reg + MONTH_W'(uctl.inc);
                D_DAY:    day_reg    <= day_reg + DAY_W'(uctl.inc);
                D_HOUR:   hour_reg   <= hour_reg + HOUR_W'(uctl.inc);
                D_MINUTE: minute_reg <= minute_reg + MIN_W'(uctl.inc);
                default:  minute_reg <= minute_reg;
            endcase
        end
    end

    assign year         = year_reg;
    assign month        = month_reg;
    assign day_of_month = day_reg;
    assign hour         = hour_reg;
    assign minute       = minute_reg;
    // after the minute walk only seconds remain
    assign second       = rem_reg[SEC_W-1:0];

endmodule

[hdl/ecd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecd_checker
// Port-level checks on the date converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "epoch_to_calendar_date_macros.svh"

module ecd_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [ecd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import ecd_pkg::*;

    // one item in flight: the input closes right after a transaction
    `ECD_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input accepted while busy")

    // a stalled result holds
    `ECD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    `ECD_ASSERT_NOW(a_date_range, m_axis_tvalid, m_axis_tdata[11:0] >= 12'd1970 && m_axis_tdata[11:0] <= 12'd2106 && m_axis_tdata[15:12] != 4'd0 && m_axis_tdata[15:12] <= 4'd12 && m_axis_tdata[20:16] != 5'd0, "date field out of range")

    `ECD_ASSERT_NOW(a_time_range, m_axis_tvalid, m_axis_tdata[25:21] < 5'd24 && m_axis_tdata[31:26] < 6'd60 && m_axis_tdata[37:32] < 6'd60 && m_axis_tdata[39:38] == 2'd0, "time field out of range")

endmodule

bind epoch_to_calendar_date ecd_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression for epoch_to_calendar_date: streams UTC second counts into the
// block under a series of zone offsets, from the reset value out to the
// 17-bit extremes. Every transaction is predicted by an independent calendar
// walk, and each returned date is compared field by field.
// ----------------------------------------------------------------------------
module tb;

    import ecd_pkg::*;

    class date_scoreboard;

        typedef struct packed {
            logic [YEAR_W-1:0]  year;
            logic [MONTH_W-1:0] month;
            logic [DAY_W-1:0]   day;
            logic [HOUR_W-1:0]  hour;
            logic [MIN_W-1:0]   minute;
            logic [SEC_W-1:0]   second;
        } cal_date_t;

        cal_date_t dates_due[$];
        int        mismatches = 0;

        static function bit is_leap(int unsigned y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        static function int unsigned month_days(int unsigned m, bit leap);
            case (m)
                2:             return leap ? 29 : 28;
                4, 6, 9, 11:   return 30;
                default:       return 31;
            endcase
        endfunction

        // walk whole years, then months, then split the remainder
        function cal_date_t local_date(logic [EPOCH_W-1:0] epoch,
                                       logic signed [TZ_W-1:0] tz);
            logic [EPOCH_W-1:0] t;
            longint unsigned    acc;
            longint unsigned    rem;
            longint unsigned    ylen;
            int unsigned        yr;
            int unsigned        mo;
            cal_date_t          d;
            t    = epoch + {{(EPOCH_W-TZ_W){tz[TZ_W-1]}}, tz};
            acc  = 0;
            yr   = 1970;
            ylen = (is_leap(yr) ? 366 : 365) * 86400;
            while (acc + ylen <= t)
            begin
                acc  += ylen;
                yr++;
                ylen = (is_leap(yr) ? 366 : 365) * 86400;
            end
            rem = t - acc;
            mo  = 1;
            while (mo < 12 && rem >= month_days(mo, is_leap(yr)) * 86400)
            begin
                rem -= month_days(mo, is_leap(yr)) * 86400;
                mo++;
            end
            d.year   = YEAR_W'(yr);
            d.month  = MONTH_W'(mo);
            d.day    = DAY_W'(rem / 86400 + 1);
            rem      = rem % 86400;
            d.hour   = HOUR_W'(rem / 3600);
            rem      = rem % 3600;
            d.minute = MIN_W'(rem / 60);
            d.second = SEC_W'(rem % 60);
            return d;
        endfunction

        function void note_epoch(logic [EPOCH_W-1:0] epoch, logic signed [TZ_W-1:0] tz);
            dates_due.push_back(local_date(epoch, tz));
        endfunction

        task report(string field, longint unsigned got, longint unsigned want);
            $display("%0t: mismatch in %s: got %0d, predicted %0d", $time, field, got, want);
            mismatches++;
        endtask

        task check_date(logic [OUT_TDATA_W-1:0] td);
            cal_date_t want;
            if (dates_due.size() == 0)
            begin
                report("unpredicted result", td, 0);
                return;
            end
            want = dates_due.pop_front();
            if (td[11:0]  != want.year)   report("year", td[11:0], want.year);
            if (td[15:12] != want.month)  report("month", td[15:12], want.month);
            if (td[20:16] != want.day)    report("day_of_month", td[20:16], want.day);
            if (td[25:21] != want.hour)   report("hour", td[25:21], want.hour);
            if (td[31:26] != want.minute) report("minute", td[31:26], want.minute);
            if (td[37:32] != want.second) report("second", td[37:32], want.second);
            if (td[39:38] != 2'b00)       report("pad bits", td[39:38], 0);
        endtask

    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic signed [TZ_W-1:0]   cfg_wr_data = '0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [EPOCH_W-1:0]       s_axis_tdata = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]   m_axis_tdata;

    date_scoreboard           board = new();
    logic signed [TZ_W-1:0]   zone = TZ_RESET;
    bit                       steady = 1'b0;
    bit                       hold_req = 1'b0;
    int                       hold_left = 0;

    epoch_to_calendar_date u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // result side: check, then pick next ready; a hold request stalls it for a long stretch
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_date(m_axis_tdata);
        if (hold_req)
        begin
            hold_left = 800;
            hold_req  = 1'b0;
        end
        if (hold_left != 0)
        begin
            hold_left     = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= steady || ($urandom_range(0, 99) >= 21);
    end

    // UTC count that lands on the given local time under the current zone
    function automatic logic [EPOCH_W-1:0] epoch_for(int unsigned y, int unsigned m,
                                                     longint secs);
        longint start;
        start = 0;
        for (int unsigned yy = 1970; yy < y; yy++)
            start += (date_scoreboard::is_leap(yy) ? 366 : 365) * 86400;
        for (int unsigned mm = 1; mm < m; mm++)
            start += date_scoreboard::month_days(mm, date_scoreboard::is_leap(y)) * 86400;
        return EPOCH_W'(start + secs - longint'(zone));
    endfunction

    task automatic send_epoch(input logic [EPOCH_W-1:0] epoch);
        if (!steady && $urandom_range(0, 99) < 21)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= epoch;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_epoch(epoch, zone);
    endtask

    task automatic send_local(input int unsigned y, input int unsigned m, input int unsigned d,
                              input int unsigned h, input int unsigned mi, input int unsigned s);
        send_epoch(epoch_for(y, m, longint'(d - 1) * 86400 + h * 3600 + mi * 60 + s));
    endtask

    // write the zone only once the stream is drained
    task automatic set_zone(input logic signed [TZ_W-1:0] tz);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (board.dates_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= tz;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        zone        = tz;
    endtask

    task automatic send_random();
        int     pick;
        longint secs;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            send_epoch($urandom());
        else if (pick < 88)
        begin
            // land near a day, month or year edge of local time
            secs = longint'($urandom_range(0, 30)) * 86400
                 + ($urandom_range(0, 1) ? 86399 : 0) + longint'($urandom_range(0, 4)) - 2;
            send_epoch(epoch_for($urandom_range(1970, 2106), $urandom_range(1, 12), secs));
        end
        else if (pick < 94)
            send_epoch($urandom_range(0, 100000));
        else
            send_epoch(32'hFFFF_FFFF - $urandom_range(0, 100000));
    endtask

    initial
    begin
        int zone_plan [9];
        zone_plan[0] = TZ_RESET;
        zone_plan[1] = 0;
        zone_plan[2] = 50400;
        zone_plan[3] = -50400;
        zone_plan[4] = 65535;
        zone_plan[5] = -65536;
        zone_plan[6] = int'($urandom_range(0, 100800)) - 50400;
        zone_plan[7] = $urandom();
        zone_plan[8] = TZ_RESET;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        for (int p = 0; p < 9; p++)
        begin
            if (p > 0)
                set_zone(TZ_W'(zone_plan[p]));
            steady = (p == 1);
            if (p == 2)
                hold_req = 1'b1;
            if (p == 0)
            begin
                // calendar corners: epoch start, leap days, century rules, a date near the 2106 end
                send_local(1970, 1, 1, 0, 0, 0);
                send_local(1970, 12, 31, 23, 59, 59);
                send_local(1971, 1, 1, 0, 0, 0);
                send_local(1972, 2, 29, 12, 0, 0);
                send_local(1972, 3, 1, 0, 0, 0);
                send_local(1999, 12, 31, 23, 59, 59);
                send_local(2000, 2, 29, 23, 59, 59);
                send_local(2000, 3, 1, 0, 0, 0);
                send_local(2038, 1, 19, 3, 14, 7);
                send_local(2100, 2, 28, 23, 59, 59);
                send_local(2100, 3, 1, 0, 0, 0);
                send_local(2106, 2, 7, 6, 28, 15);
            end
            if (p >= 2 && p <= 5)
            begin
                // raw ends of the input range; with an offset the sum wraps
                send_epoch(32'h0000_0000);
                send_epoch(32'hFFFF_FFFF);
            end
            for (int i = 0; i < 128; i++)
                send_random();
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (board.dates_due.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (board.mismatches == 0)
            $display("epoch_to_calendar_date regression: pass");
        else
            $display("epoch_to_calendar_date regression: fail");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("epoch_to_calendar_date regression: fail");
        $finish;
    end

endmodule
